FILE: rtl/core/mesh_bounds_box_and_sphere_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mesh bounds block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MESH_BOUNDS_BOX_AND_SPHERE_ASSERT_SVH
`define MESH_BOUNDS_BOX_AND_SPHERE_ASSERT_SVH
`ifndef SYNTHESIS
`define MBBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mbbs check failed");
`define MBBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbbs check failed");
`else
`define MBBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MBBS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/mbbs_pkg.sv
// ----------------------------------------------------------------------------
// mbbs_pkg
// Shared types and codes of the mesh bounds block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbbs_pkg;

  // Operation codes carried on the input channel.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  // Step commands from the sequencer to the distance unit.
  typedef struct packed {
    logic  clear;
    logic  diff;
    logic  mul;
    logic  add;
    logic  cmp;
    axis_e axis;
  } dist_ctrl_t;

endpackage

FILE: rtl/core/mbbs_in_if.sv
// ----------------------------------------------------------------------------
// mbbs_in_if
// Input channel: one vertex load or one finish request per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbbs_in_if #(
  parameter int CW = 24
) ();
  logic                 valid;
  logic                 ready;
  logic                 operation;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;

  modport source (output valid, operation, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, operation, pos_x, pos_y, pos_z, output ready);
endinterface

FILE: rtl/core/mbbs_out_if.sv
// ----------------------------------------------------------------------------
// mbbs_out_if
// Result channel: box, sphere center, radius and overflow per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mbbs_out_if #(
  parameter int CW = 24
) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] box_min_x;
  logic signed [CW-1:0] box_min_y;
  logic signed [CW-1:0] box_min_z;
  logic signed [CW-1:0] box_max_x;
  logic signed [CW-1:0] box_max_y;
  logic signed [CW-1:0] box_max_z;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic signed [CW-1:0] center_z;
  logic        [CW:0]   radius;
  logic                 overflow;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           center_x, center_y, center_z, radius, overflow,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
           center_x, center_y, center_z, radius, overflow,
    output ready
  );
endinterface

FILE: rtl/core/mbbs_store.sv
// ----------------------------------------------------------------------------
// mbbs_store
// Vertex memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbbs_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 72
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/mbbs_dist.sv
// ----------------------------------------------------------------------------
// mbbs_dist
// Shared distance unit: one axis difference, one square and one accumulate
// per step, plus the running maximum of the squared distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbbs_dist
  import mbbs_pkg::*;
#(
  parameter int CW = 24
) (
  input  logic              clk_i,
  input  dist_ctrl_t        ctrl_i,
  input  logic [3*CW-1:0]   vtx_i,
  input  logic [3*CW-1:0]   ctr_i,
  output logic [2*CW-1:0]   best_o
);

  logic signed [CW-1:0] v_sel;
  logic signed [CW-1:0] c_sel;
  logic signed [CW:0]   diff;
  logic        [CW:0]   diff_mag;
  logic        [CW-1:0] absd_q;
  logic      [2*CW-1:0] prod_q;
  logic      [2*CW-1:0] sum_q;
  logic      [2*CW-1:0] best_q;

  always_comb begin
    case (ctrl_i.axis)
      AXIS_X: begin
        v_sel = vtx_i[0 +: CW];
        c_sel = ctr_i[0 +: CW];
      end
      AXIS_Y: begin
        v_sel = vtx_i[CW +: CW];
        c_sel = ctr_i[CW +: CW];
      end
      AXIS_Z: begin
        v_sel = vtx_i[2*CW +: CW];
        c_sel = ctr_i[2*CW +: CW];
      end
      default: begin
        v_sel = '0;
        c_sel = '0;
      end
    endcase
    diff     = {v_sel[CW-1], v_sel} - {c_sel[CW-1], c_sel};
    diff_mag = diff[CW] ? (~diff + 1'b1) : diff;
  end

  // The magnitude never exceeds half the coordinate range, so it fits CW bits.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.diff) begin
      absd_q <= diff_mag[CW-1:0];
    end
    if (ctrl_i.mul) begin
      prod_q <= absd_q * absd_q;
    end
    if (ctrl_i.clear) begin
      sum_q  <= '0;
      best_q <= '0;
    end else if (ctrl_i.add) begin
      sum_q <= sum_q + prod_q;
    end else if (ctrl_i.cmp) begin
      if (sum_q > best_q) begin
        best_q <= sum_q;
      end
      sum_q <= '0;
    end
  end

  assign best_o = best_q;

endmodule

FILE: rtl/core/mbbs_sqrt.sv
// ----------------------------------------------------------------------------
// mbbs_sqrt
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbbs_sqrt #(
  parameter int CW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*CW-1:0] rad_i,
  output logic            done_o,
  output logic [CW-1:0]   root_o
);

  localparam int SW = $clog2(CW + 1);

  logic            busy_q;
  logic            done_q;
  logic [SW-1:0]   step_q;
  logic [2*CW-1:0] rad_q;
  logic [CW+1:0]   rem_q;
  logic [CW-1:0]   root_q;
  logic [CW+1:0]   rem_sh;
  logic [CW+1:0]   trial;
  logic            fits;

  // The remainder stays below 2^CW before each step, so its top bits are zero.
  always_comb begin
    rem_sh = {rem_q[CW-1:0], rad_q[2*CW-1 -: 2]};
    trial  = {root_q, 2'b01};
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= SW'(CW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == SW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_q << 2;
      if (fits) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[CW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[CW-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

FILE: rtl/core/mesh_bounds_box_and_sphere.sv
// ----------------------------------------------------------------------------
// mesh_bounds_box_and_sphere
// Axis-aligned bounding box and bounding sphere of a loaded vertex set.
// ----------------------------------------------------------------------------
// A load transfer stores one signed fixed-point vertex and updates the running
// per-axis minimum and maximum; loads are taken one per cycle, back to back,
// and even while an earlier result still waits on the output. Once the store
// holds MAX_VERTICES vertices, further loads are dropped and the overflow flag
// is set. A finish transfer reports the box, the sphere center (floor of the
// box midpoint) and the radius (floor square root of the largest squared
// distance from the center to any stored vertex). A finish walks the stored
// vertices through the single read port of the vertex store, and each vertex
// spends a read, three difference/square/accumulate rounds of the one shared
// multiplier, and a compare; the radius then comes from a one-bit-per-cycle
// square root. With no stored vertices a finish answers with all-zero fields.
// The input is not ready while a finish is in progress. Finishing clears
// nothing: later loads extend the same point set until reset. The vertex store
// needs no clearing after reset, as only written entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mesh_bounds_box_and_sphere_assert.svh"

module mesh_bounds_box_and_sphere
  import mbbs_pkg::*;
#(
  parameter int MAX_VERTICES = 4096,
  parameter int COORD_BITS   = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbbs_in_if.sink    in_i,
  mbbs_out_if.source out_o
);

  localparam int CW   = COORD_BITS;
  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  localparam logic signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  // Sequencer states.
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CENTER = 4'd1;
  localparam logic [3:0] ST_READ   = 4'd2;
  localparam logic [3:0] ST_DIFF   = 4'd3;
  localparam logic [3:0] ST_MUL    = 4'd4;
  localparam logic [3:0] ST_ADD    = 4'd5;
  localparam logic [3:0] ST_CMP    = 4'd6;
  localparam logic [3:0] ST_START  = 4'd7;
  localparam logic [3:0] ST_ROOT   = 4'd8;
  localparam logic [3:0] ST_HOLD   = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [CNTW-1:0]      cnt_q;
  logic                 drop_q;
  logic signed [CW-1:0] min_q [3];
  logic signed [CW-1:0] max_q [3];
  logic signed [CW-1:0] pos   [3];
  logic signed [CW-1:0] ctr_q [3];
  logic signed [CW:0]   mid_sum [3];
  logic [AW-1:0]        idx_q;
  axis_e                axis_q;
  logic                 empty_q;

  logic                 in_xfer;
  logic                 full;
  logic                 load_ok;
  logic                 last_vtx;
  logic                 out_load;

  logic [3*CW-1:0]      vtx_rd;
  logic [2*CW-1:0]      best;
  logic                 root_done;
  logic [CW-1:0]        root;
  dist_ctrl_t           dctrl;

  logic                 out_valid_q;
  logic signed [CW-1:0] out_min_q [3];
  logic signed [CW-1:0] out_max_q [3];
  logic signed [CW-1:0] out_ctr_q [3];
  logic [CW:0]          out_radius_q;
  logic                 out_ovf_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign full       = (cnt_q == CNTW'(MAX_VERTICES));
  assign load_ok    = in_xfer && (in_i.operation == OP_LOAD) && !full;
  assign last_vtx   = ((CNTW'(idx_q) + CNTW'(1)) == cnt_q);
  assign out_load   = (state_q == ST_HOLD) && (!out_valid_q || out_o.ready);

  assign pos[0] = in_i.pos_x;
  assign pos[1] = in_i.pos_y;
  assign pos[2] = in_i.pos_z;

  // The midpoint sum needs one extra bit; dropping its low bit is the floor half.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      mid_sum[a] = {min_q[a][CW-1], min_q[a]} + {max_q[a][CW-1], max_q[a]};
    end
  end

  mbbs_store #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW),
    .DW    (3 * CW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (load_ok),
    .wr_addr_i (cnt_q[AW-1:0]),
    .wr_data_i ({in_i.pos_z, in_i.pos_y, in_i.pos_x}),
    .rd_en_i   (state_q == ST_READ),
    .rd_addr_i (idx_q),
    .rd_data_o (vtx_rd)
  );

  always_comb begin
    dctrl       = '0;
    dctrl.clear = (state_q == ST_CENTER);
    dctrl.diff  = (state_q == ST_DIFF);
    dctrl.mul   = (state_q == ST_MUL);
    dctrl.add   = (state_q == ST_ADD);
    dctrl.cmp   = (state_q == ST_CMP);
    dctrl.axis  = axis_q;
  end

  mbbs_dist #(
    .CW (CW)
  ) u_dist (
    .clk_i  (clk_i),
    .ctrl_i (dctrl),
    .vtx_i  (vtx_rd),
    .ctr_i  ({ctr_q[2], ctr_q[1], ctr_q[0]}),
    .best_o (best)
  );

  mbbs_sqrt #(
    .CW (CW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_START),
    .rad_i   (best),
    .done_o  (root_done),
    .root_o  (root)
  );

  // Sequencer: each stored vertex goes read, then difference, square and
  // accumulate for x, y and z in turn, then the compare against the best.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer && (in_i.operation == OP_FINISH)) begin
          state_d = (cnt_q == '0) ? ST_HOLD : ST_CENTER;
        end
      end
      ST_CENTER: state_d = ST_READ;
      ST_READ:   state_d = ST_DIFF;
      ST_DIFF:   state_d = ST_MUL;
      ST_MUL:    state_d = ST_ADD;
      ST_ADD:    state_d = (axis_q == AXIS_Z) ? ST_CMP : ST_DIFF;
      ST_CMP:    state_d = last_vtx ? ST_START : ST_READ;
      ST_START:  state_d = ST_ROOT;
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      axis_q      <= AXIS_X;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        min_q[a] <= COORD_MAX;
        max_q[a] <= COORD_MIN;
      end
    end else begin
      state_q <= state_d;

      if (in_xfer && (in_i.operation == OP_LOAD)) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
          for (int a = 0; a < 3; a++) begin
            if (pos[a] < min_q[a]) begin
              min_q[a] <= pos[a];
            end
            if (pos[a] > max_q[a]) begin
              max_q[a] <= pos[a];
            end
          end
        end
      end

      if (in_xfer && (in_i.operation == OP_FINISH)) begin
        empty_q <= (cnt_q == '0);
      end

      if (state_q == ST_CENTER) begin
        idx_q  <= '0;
        axis_q <= AXIS_X;
      end else if (state_q == ST_ADD) begin
        unique case (axis_q)
          AXIS_X:  axis_q <= AXIS_Y;
          AXIS_Y:  axis_q <= AXIS_Z;
          default: axis_q <= AXIS_X;
        endcase
      end else if (state_q == ST_CMP) begin
        idx_q <= idx_q + 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Center and result payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CENTER) begin
      for (int a = 0; a < 3; a++) begin
        ctr_q[a] <= mid_sum[a][CW:1];
      end
    end
    if (out_load) begin
      for (int a = 0; a < 3; a++) begin
        out_min_q[a] <= empty_q ? '0 : min_q[a];
        out_max_q[a] <= empty_q ? '0 : max_q[a];
        out_ctr_q[a] <= empty_q ? '0 : ctr_q[a];
      end
      out_radius_q <= empty_q ? '0 : {1'b0, root};
      out_ovf_q    <= drop_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.box_min_x = out_min_q[0];
  assign out_o.box_min_y = out_min_q[1];
  assign out_o.box_min_z = out_min_q[2];
  assign out_o.box_max_x = out_max_q[0];
  assign out_o.box_max_y = out_max_q[1];
  assign out_o.box_max_z = out_max_q[2];
  assign out_o.center_x  = out_ctr_q[0];
  assign out_o.center_y  = out_ctr_q[1];
  assign out_o.center_z  = out_ctr_q[2];
  assign out_o.radius    = out_radius_q;
  assign out_o.overflow  = out_ovf_q;

  // The fill count never passes the store's capacity.
  `MBBS_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNTW'(MAX_VERTICES))
  // The walk only reads entries that were written.
  `MBBS_ASSERT_IMP(a_walk_in_range, clk_i, rst_ni, state_q == ST_READ,
                   CNTW'(idx_q) < cnt_q)
  // The overflow flag is raised only by a load that met a full store.
  `MBBS_ASSERT_IMP(a_drop_when_full, clk_i, rst_ni, $rose(drop_q), full)
  // A result leaves the hold state only into a presented output slot.
  `MBBS_ASSERT_NXT(a_hold_presents, clk_i, rst_ni, out_load, out_valid_q && state_q == ST_IDLE)

endmodule
